FILE: rtl/eafr_pkg.sv
`timescale 1ns / 1ps

package eafr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned ADDR64_W  = 64;
  localparam int unsigned ADDR16_W  = 16;
  localparam int unsigned PLEN_W    = 16;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic [BYTE_W-1:0] START_BYTE     = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE    = 8'h7D;
  localparam logic [BYTE_W-1:0] ESCAPE_XOR     = 8'h20;
  localparam logic [BYTE_W-1:0] SUM_COMPLEMENT = 8'hFF;
  localparam logic [POS_W-1:0]  PAYLOAD_START  = 17'd21;
  localparam logic [POS_W-1:0]  LEN_OVERHEAD   = 17'd3;

  // frame positions of note (length high byte is position 1)
  localparam logic [POS_W-1:0]  POS_LEN_HI   = 17'd1;
  localparam logic [POS_W-1:0]  POS_LEN_LO   = 17'd2;
  localparam logic [POS_W-1:0]  POS_TYPE     = 17'd3;
  localparam logic [POS_W-1:0]  POS_A64_FIRST = 17'd4;
  localparam logic [POS_W-1:0]  POS_A64_LAST  = 17'd11;
  localparam logic [POS_W-1:0]  POS_A16_FIRST = 17'd12;
  localparam logic [POS_W-1:0]  POS_A16_LAST  = 17'd13;

  localparam logic [BYTE_W-1:0] RX_TYPE_RESET = 8'd145;

  // register byte addresses
  localparam logic [2:0] REG_RX_TYPE = 3'd0;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_SUM_GOOD = 2'd1,
    KIND_SUM_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [POS_W-1:0]     byte_position;
    logic [BYTE_W-1:0]    frame_type;
    logic                 is_rx_indicator;
    logic [ADDR64_W-1:0]  source_address64;
    logic [ADDR16_W-1:0]  source_address16;
    logic [PLEN_W-1:0]    payload_length;
  } result_t;

endpackage

FILE: rtl/eafr_in_reg.sv
`timescale 1ns / 1ps

module eafr_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [eafr_pkg::BYTE_W-1:0]  in_byte,
  output logic                         held_valid,
  input  logic                         held_ready,
  output logic [eafr_pkg::BYTE_W-1:0]  held_byte
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [eafr_pkg::BYTE_W-1:0]  byte_r;

  assign in_ready   = !valid_r || held_ready;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

FILE: rtl/eafr_parser.sv
`timescale 1ns / 1ps

module eafr_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [eafr_pkg::BYTE_W-1:0]  rx_type,
  input  logic                         in_valid,
  input  logic [eafr_pkg::BYTE_W-1:0]  in_byte,
  output logic                         res_valid,
  input  logic                         res_ready,
  output eafr_pkg::result_t            res
);

  logic                            take;
  logic                            live;
  logic [eafr_pkg::BYTE_W-1:0]     ubyte;

  logic [eafr_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [eafr_pkg::POS_W-1:0]      end_r, end_nxt;
  logic [eafr_pkg::BYTE_W-1:0]     sum_r, sum_nxt;
  logic                            esc_r, esc_nxt;
  logic                            fin_r, fin_nxt;
  logic [eafr_pkg::BYTE_W-1:0]     type_r, type_nxt;
  logic [eafr_pkg::ADDR64_W-1:0]   a64_r, a64_nxt;
  logic [eafr_pkg::ADDR16_W-1:0]   a16_r, a16_nxt;

  logic [eafr_pkg::POS_W-1:0]      pos_inc;
  logic                            is_rx;
  logic                            sum_good;

  assign take     = in_valid && res_ready;
  assign pos_inc  = pos_r + 17'd1;
  assign is_rx    = (end_r > eafr_pkg::LEN_OVERHEAD) && (type_r == rx_type);
  assign sum_good = (eafr_pkg::SUM_COMPLEMENT - sum_r) == ubyte;

  always_comb begin
    pos_nxt   = pos_r;
    end_nxt   = end_r;
    sum_nxt   = sum_r;
    esc_nxt   = esc_r;
    fin_nxt   = fin_r;
    type_nxt  = type_r;
    a64_nxt   = a64_r;
    a16_nxt   = a16_r;
    live      = 1'b0;
    ubyte     = in_byte;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = eafr_pkg::KIND_DATA;

    if (take) begin
      priority if (in_byte == eafr_pkg::START_BYTE) begin
        // a start byte always opens a fresh frame
        pos_nxt  = '0;
        end_nxt  = '0;
        sum_nxt  = '0;
        esc_nxt  = 1'b0;
        fin_nxt  = 1'b0;
        type_nxt = '0;
        a64_nxt  = '0;
        a16_nxt  = '0;
      end else if (fin_r) begin
        // drop bytes until the next start byte
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        ubyte   = in_byte ^ eafr_pkg::ESCAPE_XOR;
        live    = 1'b1;
      end else if (in_byte == eafr_pkg::ESCAPE_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        live = 1'b1;
      end
    end

    if (live) begin
      pos_nxt = pos_inc;
      priority if (pos_inc == eafr_pkg::POS_LEN_HI) begin
        end_nxt = {1'b0, ubyte, 8'h00};
      end else if (pos_inc == eafr_pkg::POS_LEN_LO) begin
        end_nxt = (end_r | {9'd0, ubyte}) + eafr_pkg::LEN_OVERHEAD;
      end else if (pos_inc == end_r) begin
        fin_nxt             = 1'b1;
        res_valid           = 1'b1;
        res.kind            = sum_good ? eafr_pkg::KIND_SUM_GOOD : eafr_pkg::KIND_SUM_BAD;
        res.frame_type      = type_r;
        res.is_rx_indicator = is_rx;
        if (is_rx) begin
          res.source_address64 = a64_r;
          res.source_address16 = a16_r;
          if (end_r > eafr_pkg::PAYLOAD_START) begin
            res.payload_length = eafr_pkg::PLEN_W'(end_r - eafr_pkg::PAYLOAD_START);
          end
        end
      end else begin
        sum_nxt           = sum_r + ubyte;
        res_valid         = 1'b1;
        res.data_byte     = ubyte;
        res.byte_position = pos_inc;
        if (pos_inc == eafr_pkg::POS_TYPE) begin
          type_nxt = ubyte;
        end else if (pos_inc >= eafr_pkg::POS_A64_FIRST &&
                     pos_inc <= eafr_pkg::POS_A64_LAST) begin
          a64_nxt = {a64_r[eafr_pkg::ADDR64_W-9:0], ubyte};
        end else if (pos_inc == eafr_pkg::POS_A16_FIRST ||
                     pos_inc == eafr_pkg::POS_A16_LAST) begin
          a16_nxt = {a16_r[eafr_pkg::ADDR16_W-9:0], ubyte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      end_r  <= '0;
      sum_r  <= '0;
      esc_r  <= 1'b0;
      fin_r  <= 1'b0;
      type_r <= '0;
      a64_r  <= '0;
      a16_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      end_r  <= end_nxt;
      sum_r  <= sum_nxt;
      esc_r  <= esc_nxt;
      fin_r  <= fin_nxt;
      type_r <= type_nxt;
      a64_r  <= a64_nxt;
      a16_r  <= a16_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && fin_r && in_byte != eafr_pkg::START_BYTE) |-> !res_valid)
    else $error("result produced after frame end");

  a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == eafr_pkg::KIND_DATA) |-> res.byte_position >= eafr_pkg::POS_TYPE)
    else $error("data byte at length position");

  a_esc_set: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_byte == eafr_pkg::ESCAPE_BYTE && !esc_r && !fin_r) |=> esc_r)
    else $error("escape byte not recorded");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r > eafr_pkg::POS_LEN_LO && !fin_r) |-> pos_r < end_r)
    else $error("frame position ran past checksum");
`endif

endmodule

FILE: rtl/eafr_out_reg.sv
`timescale 1ns / 1ps

module eafr_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  eafr_pkg::result_t  in_res,
  output logic               out_valid,
  input  logic               out_ready,
  output eafr_pkg::result_t  out_res
);

  logic               valid_r;
  logic               valid_nxt;
  eafr_pkg::result_t  res_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

endmodule

FILE: rtl/escaped_api_frame_receiver.sv
`timescale 1ns / 1ps

// Channel  Ports                     Carries
// in       in_tvalid/tready/tdata    one raw received byte, still escaped
// out      out_tvalid/tready/tdata   frame data byte or end-of-frame verdict
//          out_tuser                 result kind
// cfg      cfg_p*                    rx indicator type register at addresses 0 to 3
//
// One byte is taken every cycle unless in_tready is low. The parser works on a
// byte while it sits in the input register, so its result passes from there into
// the output register and onto out_tdata.
// Start, escape, length and ignored bytes give no result transaction.
// rst_n is synchronous; it clears the frame state and sets the type to 145.
// A stall on out_tready fills the output register, then the input register,
// and only then drops in_tready.
module escaped_api_frame_receiver (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  // [7:0] data_byte, [24:8] byte_position, [32:25] frame_type,
  // [33] is_rx_indicator, [97:34] source_address64, [113:98] source_address16,
  // [129:114] payload_length, [135:130] zero
  output logic [135:0]  out_tdata,
  output logic [1:0]    out_tuser,  // [1:0] result_kind
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic [eafr_pkg::BYTE_W-1:0]  rx_type_r;
  logic [eafr_pkg::BYTE_W-1:0]  rx_type_nxt;
  logic                         reg_hit;

  logic                         held_valid;
  logic                         held_ready;
  logic [eafr_pkg::BYTE_W-1:0]  held_byte;
  logic                         res_valid;
  eafr_pkg::result_t            res;
  eafr_pkg::result_t            out_res;

  assign cfg_pready = 1'b1;
  assign reg_hit    = cfg_paddr[2] == eafr_pkg::REG_RX_TYPE[2];
  assign cfg_prdata = reg_hit ? {24'd0, rx_type_r} : 32'd0;

  always_comb begin
    rx_type_nxt = rx_type_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      rx_type_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_type_r <= eafr_pkg::RX_TYPE_RESET;
    end else begin
      rx_type_r <= rx_type_nxt;
    end
  end

  eafr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .held_valid (held_valid),
    .held_ready (held_ready),
    .held_byte  (held_byte)
  );

  eafr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_type   (rx_type_r),
    .in_valid  (held_valid),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res_ready (held_ready),
    .res       (res)
  );

  eafr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (held_ready),
    .in_res    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {6'd0,
                      out_res.payload_length,
                      out_res.source_address16,
                      out_res.source_address64,
                      out_res.is_rx_indicator,
                      out_res.frame_type,
                      out_res.byte_position,
                      out_res.data_byte};

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [7:0]    in_tdata = 8'h00;    // [7:0] rx_byte
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  // [7:0] data_byte, [24:8] byte_position, [32:25] frame_type,
  // [33] is_rx_indicator, [97:34] source_address64, [113:98] source_address16,
  // [129:114] payload_length, [135:130] zero
  logic [135:0]  out_tdata;
  logic [1:0]    out_tuser;           // [1:0] result_kind
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [2:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  escaped_api_frame_receiver DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // parser state mirrored from the incoming byte stream
  logic [eafr_pkg::POS_W-1:0]    frame_pos;
  logic [eafr_pkg::POS_W-1:0]    checksum_pos;
  logic [eafr_pkg::BYTE_W-1:0]   data_sum;
  logic                          esc_armed;
  logic                          frame_done;
  logic [eafr_pkg::BYTE_W-1:0]   type_seen;
  logic [eafr_pkg::ADDR64_W-1:0] src64_seen;
  logic [eafr_pkg::ADDR16_W-1:0] src16_seen;
  logic [eafr_pkg::BYTE_W-1:0]   rx_type_cfg;

  eafr_pkg::result_t   results_due[$];
  int unsigned         mismatch_count = 0;
  int unsigned         bytes_sent = 0;
  bit                  steady = 1'b0;

  task automatic open_frame();
    frame_pos    = '0;
    checksum_pos = '0;
    data_sum     = '0;
    esc_armed    = 1'b0;
    frame_done   = 1'b0;
    type_seen    = '0;
    src64_seen   = '0;
    src16_seen   = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] raw);
    logic [7:0]                 c;
    logic [eafr_pkg::POS_W-1:0] plen_full;
    logic                       is_rx;
    eafr_pkg::result_t          r;
    c = raw;
    r = '0;
    if (raw == eafr_pkg::START_BYTE) begin
      open_frame();
      return;
    end
    if (frame_done) return;
    if (esc_armed) begin
      esc_armed = 1'b0;
      c = raw ^ eafr_pkg::ESCAPE_XOR;
    end else if (raw == eafr_pkg::ESCAPE_BYTE) begin
      esc_armed = 1'b1;
      return;
    end
    frame_pos = frame_pos + 1'b1;
    if (frame_pos == eafr_pkg::POS_LEN_HI) begin
      checksum_pos = {1'b0, c, 8'h00};
      return;
    end
    if (frame_pos == eafr_pkg::POS_LEN_LO) begin
      checksum_pos = (checksum_pos | {9'd0, c}) + eafr_pkg::LEN_OVERHEAD;
      return;
    end
    if (frame_pos == checksum_pos) begin
      frame_done = 1'b1;
      is_rx = (checksum_pos > eafr_pkg::LEN_OVERHEAD) && (type_seen == rx_type_cfg);
      r.kind = ((eafr_pkg::SUM_COMPLEMENT - data_sum) == c) ? eafr_pkg::KIND_SUM_GOOD
                                                           : eafr_pkg::KIND_SUM_BAD;
      r.frame_type = type_seen;
      r.is_rx_indicator = is_rx;
      if (is_rx) begin
        r.source_address64 = src64_seen;
        r.source_address16 = src16_seen;
        plen_full = checksum_pos - eafr_pkg::PAYLOAD_START;
        r.payload_length = (checksum_pos > eafr_pkg::PAYLOAD_START) ? plen_full[15:0] : '0;
      end
      results_due.push_back(r);
      return;
    end
    data_sum = data_sum + c;
    if (frame_pos == eafr_pkg::POS_TYPE)
      type_seen = c;
    else if (frame_pos >= eafr_pkg::POS_A64_FIRST && frame_pos <= eafr_pkg::POS_A64_LAST)
      src64_seen = {src64_seen[55:0], c};
    else if (frame_pos == eafr_pkg::POS_A16_FIRST || frame_pos == eafr_pkg::POS_A16_LAST)
      src16_seen = {src16_seen[7:0], c};
    r.kind = eafr_pkg::KIND_DATA;
    r.data_byte = c;
    r.byte_position = frame_pos;
    results_due.push_back(r);
  endtask

  // result side: random stalls unless the steady stretch is on
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 12);
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    eafr_pkg::result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t ns: unexpected result: expected none, actual kind %0d tdata %h",
                   $time, out_tuser, out_tdata);
      end else begin
        e = results_due.pop_front();
        check_field("result_kind", 64'(e.kind), 64'(out_tuser));
        check_field("data_byte", 64'(e.data_byte), 64'(out_tdata[7:0]));
        check_field("byte_position", 64'(e.byte_position), 64'(out_tdata[24:8]));
        check_field("frame_type", 64'(e.frame_type), 64'(out_tdata[32:25]));
        check_field("is_rx_indicator", 64'(e.is_rx_indicator), 64'(out_tdata[33]));
        check_field("source_address64", e.source_address64, out_tdata[97:34]);
        check_field("source_address16", 64'(e.source_address16), 64'(out_tdata[113:98]));
        check_field("payload_length", 64'(e.payload_length), 64'(out_tdata[129:114]));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!steady) begin
      while ($urandom_range(99) < 12) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    parse_rx_byte(b);
  endtask

  // escape where required, and now and then where it is merely allowed
  task automatic send_escaped(input logic [7:0] b);
    if (b == eafr_pkg::START_BYTE || b == eafr_pkg::ESCAPE_BYTE ||
        ((b ^ eafr_pkg::ESCAPE_XOR) != eafr_pkg::START_BYTE && $urandom_range(99) < 4)) begin
      send_byte(eafr_pkg::ESCAPE_BYTE);
      send_byte(b ^ eafr_pkg::ESCAPE_XOR);
    end else begin
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(9))
      0: return eafr_pkg::START_BYTE;
      1: return eafr_pkg::ESCAPE_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // keep limits how many unescaped bytes after the start byte go out
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                            input bit good, input int unsigned keep);
    logic [7:0] plain[$];
    logic [7:0] b;
    logic [7:0] chk;
    plain = {};
    chk = eafr_pkg::SUM_COMPLEMENT;
    plain.push_back(len[15:8]);
    plain.push_back(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      b = (i == 0) ? ftype : pick_data_byte();
      plain.push_back(b);
      chk = chk - b;
    end
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    plain.push_back(chk);
    send_byte(eafr_pkg::START_BYTE);
    for (int i = 0; i < plain.size() && i < keep; i++)
      send_escaped(plain[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    // start and escape bytes may still sit in the pipeline
    repeat (6) @(posedge clk);
  endtask

  task automatic set_rx_type(input logic [7:0] v);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= eafr_pkg::REG_RX_TYPE;
    cfg_pwdata  <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rx_type_cfg = v;
    // read back
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("rx_indicator_type readback", 64'(v), 64'(cfg_prdata[7:0]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_frames();
    logic [7:0] seq[$];
    seq = {
      8'h00, 8'h01, 8'h55, 8'hAA,                        // frame with no start byte
      8'h13,                                             // ignored after frame end
      8'h7E, 8'h00, 8'h00, 8'hFF,                        // empty frame, good sum
      8'h7E, 8'h00, 8'h00, 8'h00,                        // empty frame, bad sum
      8'h7E, 8'h7D, 8'h7E, 8'h00, 8'h01, 8'h7D, 8'h5D, 8'h82, // start cancels escape
      8'h7E, 8'h00, 8'h02, 8'h91, 8'hFF, 8'h6F           // short rx indicator frame
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_traffic(input int unsigned goal);
    int unsigned first;
    int unsigned pick;
    logic [7:0]  ftype;
    logic [15:0] len;
    first = bytes_sent;
    while (bytes_sent - first < goal) begin
      pick  = $urandom_range(99);
      ftype = $urandom_range(1) ? rx_type_cfg : 8'($urandom_range(255));
      len   = ($urandom_range(4) == 0) ? 16'($urandom_range(25, 60))
                                       : 16'($urandom_range(0, 24));
      if (pick < 70) begin
        send_frame(ftype, len, $urandom_range(99) < 85, 32'hFFFF_FFFF);
      end else if (pick < 85) begin
        // cut short, sometimes on a dangling escape
        send_frame(ftype, len, 1'b1, $urandom_range(0, int'(len) + 2));
        if ($urandom_range(1)) send_byte(eafr_pkg::ESCAPE_BYTE);
      end else if (pick < 93) begin
        send_frame(ftype, len, 1'b1, 32'hFFFF_FFFF);
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_steady_traffic(input int unsigned goal);
    steady = 1'b1;
    test_random_traffic(goal);
    steady = 1'b0;
  endtask

  // largest length header; cut well before the checksum
  task automatic test_longest_frame();
    send_frame(rx_type_cfg, 16'hFFFF, 1'b1, 40);
  endtask

  initial begin
    open_frame();
    rx_type_cfg = eafr_pkg::RX_TYPE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_random_traffic(320);
    set_rx_type(8'h00);
    test_random_traffic(320);
    set_rx_type(8'hFF);
    test_steady_traffic(320);
    set_rx_type(8'($urandom_range(255)));
    test_random_traffic(320);
    set_rx_type(eafr_pkg::START_BYTE);
    test_random_traffic(320);
    set_rx_type(eafr_pkg::RX_TYPE_RESET);
    test_longest_frame();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
